/* design/pivc_pkg.sv */
// Shared types and constants of the incremental PI velocity controller.
package pivc_pkg;

  // Widths fixed by the register map
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 32;
  localparam int DRIVE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KP          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 3'd4;

  // Limit stage modes; the unused code behaves as no limit
  typedef enum logic [1:0] {
    SAT_NONE  = 2'd0,
    SAT_WRAP  = 2'd1,
    SAT_CLAMP = 2'd2
  } sat_mode_t;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki_period;
    logic [1:0]                sat_mode;
    logic signed [LIMIT_W-1:0] upper_limit;
    logic signed [LIMIT_W-1:0] lower_limit;
  } pivc_cfg_t;

endpackage

/* design/pivc_cfg_regs.sv */
// Configuration register file of the PI velocity controller.
module pivc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pivc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pivc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output pivc_pkg::pivc_cfg_t               cfg_o
);
  import pivc_pkg::*;

  pivc_cfg_t cfg_r;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp          <= '0;
      cfg_r.ki_period   <= '0;
      cfg_r.sat_mode    <= SAT_NONE;
      cfg_r.upper_limit <= {1'b0, {(LIMIT_W-1){1'b1}}};
      cfg_r.lower_limit <= {1'b1, {(LIMIT_W-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:          cfg_r.kp          <= cfg_wdata[GAIN_W-1:0];
        CFG_KI_PERIOD:   cfg_r.ki_period   <= cfg_wdata[GAIN_W-1:0];
        CFG_SAT_MODE:    cfg_r.sat_mode    <= cfg_wdata[1:0];
        CFG_UPPER_LIMIT: cfg_r.upper_limit <= cfg_wdata[LIMIT_W-1:0];
        CFG_LOWER_LIMIT: cfg_r.lower_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* design/pivc_front.sv */
// Input register, previous-error tracking and gain product stage.
module pivc_front #(
  parameter int ERROR_WIDTH = 16,
  parameter int KPE_W       = 32,
  parameter int DKE_W       = 33
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pivc_pkg::pivc_cfg_t            cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ERROR_WIDTH-1:0]  in_err,
  output logic                           prod_valid,
  input  logic                           prod_ready,
  output logic signed [KPE_W-1:0]        kpe,
  output logic signed [DKE_W-1:0]        dke
);
  import pivc_pkg::*;

  logic                          s1_valid_r;
  logic signed [ERROR_WIDTH-1:0] s1_err_r;
  logic signed [ERROR_WIDTH-1:0] s1_prev_r;
  logic signed [ERROR_WIDTH-1:0] prev_err_r;
  logic                          s2_valid_r;
  logic signed [KPE_W-1:0]       kpe_r;
  logic signed [DKE_W-1:0]       dke_r;
  logic signed [GAIN_W:0]        gain_diff;
  logic signed [KPE_W-1:0]       kpe_nxt;
  logic signed [DKE_W-1:0]       dke_nxt;
  logic                          s1_ready;
  logic                          s2_ready;
  logic                          s1_load;
  logic                          s2_load;

  // Each stage advances when empty or when the next one takes its beat
  assign s2_ready = !s2_valid_r || prod_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  // Capture the sample and pair it with the error of the previous beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_err_r <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_load) begin
        prev_err_r <= in_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_err_r  <= in_err;
      s1_prev_r <= prev_err_r;
    end
  end

  // Form kp*e and (ki_period - kp)*e_prev
  always_comb begin
    gain_diff = (GAIN_W+1)'(cfg.ki_period) - (GAIN_W+1)'(cfg.kp);
    kpe_nxt   = KPE_W'(cfg.kp) * KPE_W'(s1_err_r);
    dke_nxt   = DKE_W'(gain_diff) * DKE_W'(s1_prev_r);
  end

  // Hold the products for the accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      kpe_r <= kpe_nxt;
      dke_r <= dke_nxt;
    end
  end

  assign prod_valid = s2_valid_r;
  assign kpe        = kpe_r;
  assign dke        = dke_r;

endmodule

/* design/pivc_accum.sv */
// Accumulate, limit and saturate stage with the drive output register.
module pivc_accum #(
  parameter int GAIN_FRAC_BITS = 12,
  parameter int ACC_WIDTH      = 32,
  parameter int KPE_W          = 32,
  parameter int DKE_W          = 33
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pivc_pkg::pivc_cfg_t                 cfg,
  input  logic                                prod_valid,
  output logic                                prod_ready,
  input  logic signed [KPE_W-1:0]             kpe,
  input  logic signed [DKE_W-1:0]             dke,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pivc_pkg::DRIVE_W-1:0]        out_drive
);
  import pivc_pkg::*;

  localparam int PSUM_W = DKE_W + 1;
  localparam int MAX_W0 = (ACC_WIDTH > PSUM_W) ? ACC_WIDTH : PSUM_W;
  localparam int MAX_W1 = (MAX_W0 > LIMIT_W) ? MAX_W0 : LIMIT_W;
  localparam int SUM_W  = ((MAX_W1 > DRIVE_W) ? MAX_W1 : DRIVE_W) + 1;

  localparam logic signed [SUM_W-1:0] ACC_HI =
    (SUM_W'(1) <<< (ACC_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);

  logic signed [ACC_WIDTH-1:0] acc_r;
  logic                        out_valid_r;
  logic [DRIVE_W-1:0]          out_drive_r;
  logic signed [SUM_W-1:0]     psum;
  logic signed [SUM_W-1:0]     incr;
  logic signed [SUM_W-1:0]     raw;
  logic signed [SUM_W-1:0]     upper;
  logic signed [SUM_W-1:0]     lower;
  logic signed [SUM_W-1:0]     limited;
  logic signed [SUM_W-1:0]     clipped;
  logic                        take;

  assign prod_ready = !out_valid_r || out_ready;
  assign take       = prod_valid && prod_ready;

  // Scale the increment and add it to the accumulator at full precision
  always_comb begin
    psum  = SUM_W'(kpe) + SUM_W'(dke);
    incr  = psum >>> GAIN_FRAC_BITS;
    raw   = SUM_W'(acc_r) + incr;
    upper = SUM_W'(cfg.upper_limit);
    lower = SUM_W'(cfg.lower_limit);
  end

  // Apply the selected limit; the upper test wins when limits are inverted
  always_comb begin
    limited = raw;
    case (cfg.sat_mode)
      SAT_WRAP: begin
        if (raw > upper) begin
          limited = lower;
        end else if (raw < lower) begin
          limited = upper;
        end
      end
      SAT_CLAMP: begin
        if (raw > upper) begin
          limited = upper;
        end else if (raw < lower) begin
          limited = lower;
        end
      end
      default: limited = raw;
    endcase
  end

  // Saturate to the accumulator range
  always_comb begin
    if (limited > ACC_HI) begin
      clipped = ACC_HI;
    end else if (limited < ACC_LO) begin
      clipped = ACC_LO;
    end else begin
      clipped = limited;
    end
  end

  // Update the accumulator and hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (take) begin
      acc_r       <= clipped[ACC_WIDTH-1:0];
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_drive_r <= clipped[DRIVE_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

endmodule

/* design/pi_velocity_controller_saturating.sv */
// Top level of the incremental PI velocity controller with output limit.
//
// Each error beat updates drive += (kp*e + (ki_period - kp)*e_prev) >>> GAIN_FRAC_BITS
// (gains signed Q4.12), then applies the limit stage chosen by sat_mode: none
// (saturate at the accumulator range), wrap to the opposite limit, or clamp.
// The block takes one beat per clock cycle when out_tready does not hold it back,
// and returns one drive beat for every error beat. Each beat passes the input
// register, the gain product register, then the accumulate/limit stage and its
// output register. The throughput of one beat per cycle is set by the accumulator
// feedback loop, which closes inside the last stage. Write configuration only
// while no beat is in flight.
module pi_velocity_controller_saturating #(
  parameter int ERROR_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 12,
  parameter int ACC_WIDTH      = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // error_sample in the low ERROR_WIDTH bits, zero padded to whole bytes
  input  logic [((ERROR_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // drive in bits 31:0
  output logic [pivc_pkg::DRIVE_W-1:0]          out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [pivc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pivc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import pivc_pkg::*;

  localparam int KPE_W = GAIN_W + ERROR_WIDTH;
  localparam int DKE_W = GAIN_W + 1 + ERROR_WIDTH;

  pivc_cfg_t               cfg;
  logic                    prod_valid;
  logic                    prod_ready;
  logic signed [KPE_W-1:0] kpe;
  logic signed [DKE_W-1:0] dke;

  pivc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  pivc_front #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .KPE_W       (KPE_W),
    .DKE_W       (DKE_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_err     (in_tdata[ERROR_WIDTH-1:0]),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .kpe        (kpe),
    .dke        (dke)
  );

  pivc_accum #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH),
    .KPE_W          (KPE_W),
    .DKE_W          (DKE_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .kpe        (kpe),
    .dke        (dke),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_drive  (out_tdata)
  );

endmodule
